// ----- hdl/wpad_pkg.sv -----
`default_nettype none

package wpad_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int MAX_WINDOWS = 32;
	localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1);
	localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOWS);
	localparam int STEP_BITS   = $clog2(SUM_BITS);
	localparam int ADDR_BITS   = 3;
	localparam int DATA_BITS   = 32;

	localparam logic [SAMPLE_BITS-1:0] THR_RESET = SAMPLE_BITS'(2300);
	localparam logic [CNT_BITS-1:0]    WIN_RESET = CNT_BITS'(5);

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_WINDOWS   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic                start;
		logic [SUM_BITS-1:0] dividend;
		logic [CNT_BITS-1:0] divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [SUM_BITS-1:0] quotient;
	} div_stat_t;

	// zero means one, anything past the limit saturates
	function automatic logic [CNT_BITS-1:0] eff_windows(input logic [CNT_BITS-1:0] w);
		logic [CNT_BITS-1:0] r;
		r = w;
		if (w == '0)
			r = CNT_BITS'(1);
		else if (w > CNT_BITS'(MAX_WINDOWS))
			r = CNT_BITS'(MAX_WINDOWS);
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/windowed_peak_average_detector_top.sv -----
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid/in_ready    sample, window_end
// output    out_valid/out_ready  average_peak, alarm, threshold_used
// config    APB write/read       alarm_threshold @0x0, windows_per_average @0x4
//
// A sample that does not close the averaging run is taken without stalling the input.
// The sample that completes the run starts a 17-step restoring divider:
// in_ready stays low through the divide steps and until the result is loaded.
// If the output register still holds an untaken result, the block waits for it.
// arst_n clears peak, sum, count and the output valid; config registers take reset values.
module windowed_peak_average_detector_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic [wpad_pkg::SAMPLE_BITS-1:0]    sample,
	input  wire logic                                window_end,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [wpad_pkg::SAMPLE_BITS-1:0]    average_peak,
	output      logic                                alarm,
	output      logic [wpad_pkg::SAMPLE_BITS-1:0]    threshold_used,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [wpad_pkg::ADDR_BITS-1:0]      paddr,
	input  wire logic [wpad_pkg::DATA_BITS-1:0]      pwdata,
	output      logic [wpad_pkg::DATA_BITS-1:0]      prdata,
	output      logic                                pready
);

	wpad_pkg::state_t state_q, state_d;

	logic [wpad_pkg::SAMPLE_BITS-1:0] thr_q;
	logic [wpad_pkg::CNT_BITS-1:0]    win_q;
	logic [wpad_pkg::SAMPLE_BITS-1:0] peak_q;
	logic [wpad_pkg::SUM_BITS-1:0]    sum_q;
	logic [wpad_pkg::CNT_BITS-1:0]    cnt_q;

	logic                             out_valid_q;
	logic [wpad_pkg::SAMPLE_BITS-1:0] avg_q;
	logic                             alarm_q;
	logic [wpad_pkg::SAMPLE_BITS-1:0] thr_used_q;

	logic                             accept;
	logic                             cfg_wr;
	wpad_pkg::reg_idx_t               reg_idx;
	logic [wpad_pkg::SAMPLE_BITS-1:0] peak_next;
	logic [wpad_pkg::SUM_BITS-1:0]    sum_next;
	logic [wpad_pkg::CNT_BITS-1:0]    cnt_next;
	logic                             run_done;
	logic                             slot_free;
	logic                             load_out;
	logic [wpad_pkg::SAMPLE_BITS-1:0] quo_lo;

	wpad_pkg::div_ctrl_t div_ctrl;
	wpad_pkg::div_stat_t div_stat;

	wpad_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.stat   (div_stat)
	);

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = wpad_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			wpad_pkg::REG_THRESHOLD:
				prdata = wpad_pkg::DATA_BITS'(thr_q);
			wpad_pkg::REG_WINDOWS:
				prdata = wpad_pkg::DATA_BITS'(win_q);
			default:
				prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= wpad_pkg::THR_RESET;
			win_q <= wpad_pkg::WIN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				wpad_pkg::REG_THRESHOLD:
					thr_q <= pwdata[wpad_pkg::SAMPLE_BITS-1:0];
				wpad_pkg::REG_WINDOWS:
					win_q <= pwdata[wpad_pkg::CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// window accumulation
	assign in_ready  = (state_q == wpad_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign peak_next = (sample > peak_q) ? sample : peak_q;
	assign sum_next  = sum_q + wpad_pkg::SUM_BITS'(peak_next);
	assign cnt_next  = cnt_q + 1'b1;
	// count may already exceed a lowered setting
	assign run_done  = window_end && (cnt_next >= wpad_pkg::eff_windows(win_q));

	always_comb begin
		div_ctrl.start    = accept && run_done;
		div_ctrl.dividend = sum_next;
		div_ctrl.divisor  = cnt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (window_end) begin
				peak_q <= '0;
				if (run_done) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end else begin
				peak_q <= peak_next;
			end
		end
	end

	// sequencer
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wpad_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			wpad_pkg::ST_IDLE: begin
				if (accept && run_done)
					state_d = wpad_pkg::ST_DIV;
			end
			wpad_pkg::ST_DIV: begin
				if (div_stat.done) begin
					if (slot_free) begin
						load_out = 1'b1;
						state_d  = wpad_pkg::ST_IDLE;
					end else begin
						state_d = wpad_pkg::ST_HOLD;
					end
				end
			end
			wpad_pkg::ST_HOLD: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = wpad_pkg::ST_IDLE;
				end
			end
			default: state_d = wpad_pkg::ST_IDLE;
		endcase
	end

	// result register
	assign quo_lo = div_stat.quotient[wpad_pkg::SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q      <= quo_lo;
			alarm_q    <= (quo_lo >= thr_q);
			thr_used_q <= thr_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign average_peak   = avg_q;
	assign alarm          = alarm_q;
	assign threshold_used = thr_used_q;

endmodule

`default_nettype wire

// ----- hdl/wpad_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module wpad_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wpad_pkg::div_ctrl_t ctrl,
	output wpad_pkg::div_stat_t     stat
);

	logic [wpad_pkg::SUM_BITS-1:0]  quo_q;
	logic [wpad_pkg::CNT_BITS-1:0]  rem_q;
	logic [wpad_pkg::CNT_BITS-1:0]  div_q;
	logic [wpad_pkg::STEP_BITS-1:0] step_q;
	logic                           busy_q;
	logic                           done_q;

	logic [wpad_pkg::CNT_BITS:0] trial;
	logic [wpad_pkg::CNT_BITS:0] diff;
	logic                        fits;

	always_comb begin
		trial = {rem_q, quo_q[wpad_pkg::SUM_BITS-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !ctrl.start && busy_q
				&& (step_q == wpad_pkg::STEP_BITS'(wpad_pkg::SUM_BITS - 1));
			if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == wpad_pkg::STEP_BITS'(wpad_pkg::SUM_BITS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q <= ctrl.dividend;
			rem_q <= '0;
			div_q <= ctrl.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[wpad_pkg::SUM_BITS-2:0], fits};
			rem_q <= fits ? diff[wpad_pkg::CNT_BITS-1:0] : trial[wpad_pkg::CNT_BITS-1:0];
		end
	end

	always_comb begin
		stat.busy     = busy_q;
		stat.done     = done_q;
		stat.quotient = quo_q;
	end

endmodule

`default_nettype wire

// ----- hdl/wpad_checker.sv -----
`default_nettype none

module wpad_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             window_end,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [wpad_pkg::SAMPLE_BITS-1:0] average_peak,
	input wire logic                             alarm,
	input wire logic [wpad_pkg::SAMPLE_BITS-1:0] threshold_used,
	input wire logic                             pready
);

	// a request held back keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average_peak) && $stable(alarm)
			&& $stable(threshold_used))
		else $error("result changed while stalled");

	a_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alarm == (average_peak >= threshold_used))
		else $error("alarm disagrees with average and threshold");

	// a mid-window sample never starts the divider
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !window_end |=> in_ready)
		else $error("busy after a mid-window sample");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind windowed_peak_average_detector_top wpad_checker u_wpad_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.window_end     (window_end),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.average_peak   (average_peak),
	.alarm          (alarm),
	.threshold_used (threshold_used),
	.pready         (pready)
);

`default_nettype wire

// ----- sim/windowed_peak_average_detector_top_tb.sv -----
`default_nettype none

module windowed_peak_average_detector_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wpad_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] avg;
		logic                   alarm;
		logic [SAMPLE_BITS-1:0] thr;
	} average_result_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		reg_idx_t               idx;
		logic [DATA_BITS-1:0]   wdata;
		logic [SAMPLE_BITS-1:0] smp;
		logic                   wend;
		logic [7:0]             reps;
		logic                   typed;
		average_result_t        want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] sample = '0;
	logic                   window_end = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [SAMPLE_BITS-1:0] average_peak;
	logic                   alarm;
	logic [SAMPLE_BITS-1:0] threshold_used;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_BITS-1:0]   paddr = '0;
	logic [DATA_BITS-1:0]   pwdata = '0;
	logic [DATA_BITS-1:0]   prdata;
	logic                   pready;

	// predictor copy of the block
	logic [SAMPLE_BITS-1:0] cfg_thr = THR_RESET;
	logic [CNT_BITS-1:0]    cfg_win = WIN_RESET;
	logic [SAMPLE_BITS-1:0] acc_peak = '0;
	logic [SUM_BITS-1:0]    acc_sum = '0;
	logic [CNT_BITS-1:0]    acc_count = '0;

	average_result_t pending_averages[$];
	average_result_t head_average;
	stim_row_t       plan[$];
	int              mismatches = 0;
	int              items_sent = 0;
	int              burst_left = 0;
	int              ready_mode = 0;
	int              ready_mode_left = 0;
	int              stall_left = 0;

	windowed_peak_average_detector_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.window_end(window_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average_peak(average_peak),
		.alarm(alarm),
		.threshold_used(threshold_used),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// one sample through the predictor; returns 1 when an average comes out
	function automatic logic peak_average_step(input logic [SAMPLE_BITS-1:0] s, input logic e,
			output average_result_t r);
		logic [CNT_BITS-1:0] need;
		logic [SUM_BITS-1:0] q;
		need = cfg_win;
		if (cfg_win == '0)
			need = CNT_BITS'(1);
		else if (cfg_win > CNT_BITS'(MAX_WINDOWS))
			need = CNT_BITS'(MAX_WINDOWS);
		r = '0;
		if (s > acc_peak)
			acc_peak = s;
		if (!e)
			return 1'b0;
		acc_sum = acc_sum + SUM_BITS'(acc_peak);
		acc_count = acc_count + 1'b1;
		acc_peak = '0;
		if (acc_count < need)
			return 1'b0;
		q = acc_sum / SUM_BITS'(acc_count);
		r.avg = q[SAMPLE_BITS-1:0];
		r.alarm = (q >= SUM_BITS'(cfg_thr));
		r.thr = cfg_thr;
		acc_sum = '0;
		acc_count = '0;
		return 1'b1;
	endfunction

	function automatic stim_row_t row_sample(input logic [SAMPLE_BITS-1:0] s, input logic e,
			input int n);
		stim_row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.smp = s;
		r.wend = e;
		r.reps = 8'(n);
		return r;
	endfunction

	function automatic stim_row_t row_expect(input logic [SAMPLE_BITS-1:0] s, input logic e,
			input int n, input int a, input logic al, input int t);
		stim_row_t r;
		r = row_sample(s, e, n);
		r.typed = 1'b1;
		r.want.avg = SAMPLE_BITS'(a);
		r.want.alarm = al;
		r.want.thr = SAMPLE_BITS'(t);
		return r;
	endfunction

	function automatic stim_row_t row_write(input reg_idx_t idx, input logic [DATA_BITS-1:0] d);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.wdata = d;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input average_result_t want,
			input average_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected avg=%0d alarm=%0b thr=%0d, got avg=%0d alarm=%0b thr=%0d",
				what, want.avg, want.alarm, want.thr, got.avg, got.alarm, got.thr);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_averages.size() == 0) begin
				note_mismatch("unexpected result", '0, {average_peak, alarm, threshold_used});
			end else begin
				head_average = pending_averages.pop_front();
				if (head_average.avg !== average_peak || head_average.alarm !== alarm
						|| head_average.thr !== threshold_used)
					note_mismatch("result", head_average, {average_peak, alarm, threshold_used});
			end
		end
	end

	// receiver: stall pattern switches at random among three modes
	always @(negedge clk) begin
		if (ready_mode_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_mode_left = $urandom_range(50, 300);
		end else begin
			ready_mode_left--;
		end
		if (stall_left != 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
			case (ready_mode)
				1: begin
					if ($urandom_range(0, 3) == 0)
						stall_left = $urandom_range(1, 8);
				end
				2: begin
					if ($urandom_range(0, 15) == 0)
						stall_left = $urandom_range(10, 40);
				end
				default: ;
			endcase
		end
	end

	task automatic pace_sender;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic e, input logic typed,
			input average_result_t want);
		average_result_t r;
		logic got;
		@(negedge clk);
		in_valid = 1'b1;
		sample = s;
		window_end = e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		got = peak_average_step(s, e, r);
		if (got)
			pending_averages.push_back(typed ? want : r);
		items_sent++;
		pace_sender();
	endtask

	task automatic wait_idle;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_averages.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] d);
		logic [DATA_BITS-1:0] readback;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_BITS'({idx, 2'b00});
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_THRESHOLD) begin
			cfg_thr = d[SAMPLE_BITS-1:0];
			readback = DATA_BITS'(cfg_thr);
		end else begin
			cfg_win = d[CNT_BITS-1:0];
			readback = DATA_BITS'(cfg_win);
		end
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== readback) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch register %s readback: expected %h, got %h",
					idx.name(), readback, prdata);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	initial begin
		stim_row_t       row;
		logic [DATA_BITS-1:0] d;
		logic [SAMPLE_BITS-1:0] s;
		int              phase_items;
		int              win_left;
		int              level_mode;
		int              lo;
		int              hi;

		// at reset: five windows averaged, threshold 2300
		plan.push_back(row_expect(12'd2300, 1'b1, 5, 2300, 1'b1, 2300));
		plan.push_back(row_write(REG_WINDOWS, 32'd1));
		plan.push_back(row_sample(12'd4095, 1'b0, 1));
		plan.push_back(row_expect(12'd0, 1'b1, 1, 4095, 1'b1, 2300));
		plan.push_back(row_expect(12'd0, 1'b1, 1, 0, 1'b0, 2300));
		plan.push_back(row_write(REG_THRESHOLD, 32'd0));
		plan.push_back(row_expect(12'd0, 1'b1, 1, 0, 1'b1, 0));
		plan.push_back(row_write(REG_THRESHOLD, 32'd4095));
		plan.push_back(row_expect(12'd4095, 1'b1, 1, 4095, 1'b1, 4095));
		plan.push_back(row_expect(12'd4094, 1'b1, 1, 4094, 1'b0, 4095));
		// peak held over later smaller samples
		plan.push_back(row_sample(12'd3000, 1'b0, 1));
		plan.push_back(row_sample(12'd5, 1'b0, 1));
		plan.push_back(row_sample(12'd1, 1'b1, 1));
		// zero windows acts as one
		plan.push_back(row_write(REG_WINDOWS, 32'd0));
		plan.push_back(row_expect(12'd7, 1'b1, 1, 7, 1'b0, 4095));
		// above the limit saturates; full-scale sum
		plan.push_back(row_write(REG_WINDOWS, 32'd63));
		plan.push_back(row_expect(12'd4095, 1'b1, 32, 4095, 1'b1, 4095));
		// lowered mid-average: divides by windows actually seen
		plan.push_back(row_write(REG_WINDOWS, 32'hFFFF_FFE8));
		plan.push_back(row_sample(12'd1000, 1'b1, 3));
		plan.push_back(row_write(REG_WINDOWS, 32'd2));
		plan.push_back(row_expect(12'd1000, 1'b1, 1, 1000, 1'b0, 4095));
		// upper write bits ignored
		plan.push_back(row_write(REG_THRESHOLD, 32'hFFFF_F500));
		plan.push_back(row_write(REG_WINDOWS, 32'd3));
		plan.push_back(row_sample(12'd1279, 1'b1, 1));
		plan.push_back(row_sample(12'd1280, 1'b1, 1));
		plan.push_back(row_expect(12'd1281, 1'b1, 1, 1280, 1'b1, 1280));
		plan.push_back(row_write(REG_WINDOWS, 32'd32));

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				wait_idle();
				write_reg(row.idx, row.wdata);
			end else begin
				for (int k = 0; k < row.reps; k++)
					send_sample(row.smp, row.wend, row.typed && k == row.reps - 1, row.want);
			end
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 2) != 0) begin
				d = $urandom();
				case ($urandom_range(0, 5))
					0: d[SAMPLE_BITS-1:0] = '0;
					1: d[SAMPLE_BITS-1:0] = '1;
					2: d[SAMPLE_BITS-1:0] = SAMPLE_BITS'($urandom_range(0, 400));
					default: d[SAMPLE_BITS-1:0] = SAMPLE_BITS'($urandom());
				endcase
				write_reg(REG_THRESHOLD, d);
			end
			if ($urandom_range(0, 2) != 0) begin
				d = $urandom();
				case ($urandom_range(0, 7))
					0: d[CNT_BITS-1:0] = '0;
					1: d[CNT_BITS-1:0] = CNT_BITS'($urandom_range(33, 63));
					2: d[CNT_BITS-1:0] = CNT_BITS'(MAX_WINDOWS);
					3: d[CNT_BITS-1:0] = CNT_BITS'($urandom_range(5, 12));
					default: d[CNT_BITS-1:0] = CNT_BITS'($urandom_range(1, 4));
				endcase
				write_reg(REG_WINDOWS, d);
			end
			phase_items = $urandom_range(20, 80);
			win_left = 0;
			lo = 0;
			hi = 4095;
			for (int n = 0; n < phase_items; n++) begin
				if (win_left == 0) begin
					win_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20)
						: $urandom_range(1, 6);
					level_mode = $urandom_range(0, 3);
					case (level_mode)
						0: begin
							lo = 0;
							hi = 255;
						end
						1: begin
							lo = (cfg_thr > 40) ? cfg_thr - 40 : 0;
							hi = (cfg_thr < 4055) ? cfg_thr + 40 : 4095;
						end
						default: begin
							lo = 0;
							hi = 4095;
						end
					endcase
				end
				s = SAMPLE_BITS'($urandom_range(lo, hi));
				send_sample(s, win_left == 1, 1'b0, '0);
				win_left--;
			end
		end

		wait_idle();
		if (mismatches == 0 && pending_averages.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
